// ===== hdl/wrms_pkg.sv =====
// shared types and constants for the windowed rms level meter
package wrms_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int IN_W        = 16;
  localparam int WIN_W       = 10;
  localparam int SQ_W        = 2 * IN_W;
  localparam int SUM_W       = 42;
  localparam int ROOT_W      = 16;
  localparam int SROOT_W     = SUM_W / 2;
  localparam int REM_W       = SROOT_W + 2;
  localparam int STEP_W      = 6;

  localparam logic [WIN_W-1:0]  WIN_RESET   = WIN_W'(500);
  localparam logic [IN_W-1:0]   SAMPLE_MASK = IN_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST   = STEP_W'(SROOT_W - 1);

  typedef struct packed {
    logic load;       // take the sample transfer
    logic square;
    logic accum;
    logic div_step;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic window_done;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/wrms_ctrl.sv =====
// controller state machine of the windowed rms level meter
module wrms_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  wrms_pkg::status_t status,
  output wrms_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQUARE = 3'd1;
  localparam logic [2:0] S_ACCUM  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_SQRT   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]                  state, state_next;
  logic [wrms_pkg::STEP_W-1:0] step, step_next;

  assign sample_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        step_next = '0;
        state_next = status.window_done ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == wrms_pkg::DIV_LAST) begin
          step_next  = '0;
          state_next = S_SQRT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step == wrms_pkg::SQRT_LAST) begin
          step_next  = '0;
          state_next = S_FINISH;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_FINISH: begin
        // wait until the output register can take the result
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ===== hdl/wrms_dp.sv =====
// datapath: squarer, accumulator, serial divider, serial square root, output register
module wrms_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [wrms_pkg::IN_W-1:0]    sample,
  input  logic                         window_length_we,
  input  logic [wrms_pkg::WIN_W-1:0]   window_length,
  input  wrms_pkg::cmd_t               cmd,
  output wrms_pkg::status_t            status,
  output logic                         rms_valid,
  input  logic                         rms_stall,
  output logic [wrms_pkg::ROOT_W-1:0]  rms_level
);

  logic [wrms_pkg::WIN_W-1:0]  win_reg;
  logic [wrms_pkg::WIN_W-1:0]  win;
  logic [wrms_pkg::WIN_W-1:0]  divisor;
  logic [wrms_pkg::IN_W-1:0]   sample_reg;
  logic [wrms_pkg::SQ_W-1:0]   product;
  logic [wrms_pkg::SUM_W-1:0]  square_sum;
  logic [wrms_pkg::SUM_W-1:0]  sum_next;
  logic [wrms_pkg::WIN_W-1:0]  sample_count;
  logic [wrms_pkg::WIN_W:0]    count_next;
  logic                        window_done;

  // divider: dq shifts the dividend out and the quotient in
  logic [wrms_pkg::SUM_W-1:0]  dq;
  logic [wrms_pkg::WIN_W-1:0]  drem;
  logic [wrms_pkg::WIN_W:0]    drem_sh;
  logic [wrms_pkg::WIN_W:0]    drem_diff;
  logic                        qbit;

  // square root works on the whole quotient, two bits a step
  logic [wrms_pkg::SUM_W-1:0]   rad;
  logic [wrms_pkg::REM_W-1:0]   srem;
  logic [wrms_pkg::SROOT_W-1:0] root;
  logic [wrms_pkg::REM_W+1:0]   srem_sh;
  logic [wrms_pkg::REM_W+1:0]   trial;
  logic                         rbit;

  assign win         = (win_reg == '0) ? wrms_pkg::WIN_W'(1) : win_reg;
  assign sum_next    = square_sum + {{(wrms_pkg::SUM_W - wrms_pkg::SQ_W){1'b0}}, product};
  assign count_next  = {1'b0, sample_count} + 1'b1;
  assign window_done = (count_next >= {1'b0, win});

  assign drem_sh   = {drem, dq[wrms_pkg::SUM_W-1]};
  assign drem_diff = drem_sh - {1'b0, divisor};
  assign qbit      = (drem_sh >= {1'b0, divisor});

  assign srem_sh = {srem, rad[wrms_pkg::SUM_W-1 -: 2]};
  assign trial   = {{2{1'b0}}, root, 2'b01};
  assign rbit    = (srem_sh >= trial);

  assign status.window_done = window_done;
  assign status.out_free    = !rms_valid || !rms_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg      <= wrms_pkg::WIN_RESET;
      square_sum   <= '0;
      sample_count <= '0;
      rms_valid    <= 1'b0;
    end else begin
      if (window_length_we) begin
        win_reg <= window_length;
      end
      if (cmd.accum) begin
        if (window_done) begin
          square_sum   <= '0;
          sample_count <= '0;
        end else begin
          square_sum   <= sum_next;
          sample_count <= count_next[wrms_pkg::WIN_W-1:0];
        end
      end
      if (cmd.out_load) begin
        rms_valid <= 1'b1;
      end else if (rms_valid && !rms_stall) begin
        rms_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_reg <= sample & wrms_pkg::SAMPLE_MASK;
    end
    if (cmd.square) begin
      product <= wrms_pkg::SQ_W'(sample_reg) * wrms_pkg::SQ_W'(sample_reg);
    end
    if (cmd.accum) begin
      dq      <= sum_next;
      divisor <= win;
      drem    <= '0;
      srem    <= '0;
      root    <= '0;
    end
    if (cmd.div_step) begin
      dq   <= {dq[wrms_pkg::SUM_W-2:0], qbit};
      drem <= qbit ? drem_diff[wrms_pkg::WIN_W-1:0] : drem_sh[wrms_pkg::WIN_W-1:0];
    end
    if (cmd.div_step && (cmd.sqrt_step == 1'b0)) begin
      // a window cut short can leave a quotient above 32 bits, so keep all of it
      rad <= {dq[wrms_pkg::SUM_W-2:0], qbit};
    end
    if (cmd.sqrt_step) begin
      rad  <= {rad[wrms_pkg::SUM_W-3:0], 2'b00};
      srem <= rbit ? wrms_pkg::REM_W'(srem_sh - trial) : srem_sh[wrms_pkg::REM_W-1:0];
      root <= {root[wrms_pkg::SROOT_W-2:0], rbit};
    end
    if (cmd.out_load) begin
      rms_level <= root[wrms_pkg::ROOT_W-1:0];
    end
  end

endmodule

// ===== hdl/windowed_rms_level_meter.sv =====
// top level of the windowed rms level meter
//
// sample channel: sample_valid / sample_stall / sample. a transfer happens
// on a rising edge with sample_valid high and sample_stall low. only the low
// SAMPLE_BITS bits of a sample are used.
// result channel: rms_valid / rms_stall / rms_level, one result per window,
// floor(sqrt(floor(sum of squares / window_length))), low 16 bits.
// window_length is written through window_length_we; 0 acts as 1.
// each sample is captured, multiplied and accumulated, and sample_stall
// stays high until it is through. the sample that closes its window then
// goes on through the bit-serial divider and the digit-serial square root
// and waits to load the output register. the output register holds a
// result while rms_stall is high; new samples are still taken then, until
// the next window's result waits for it, which stalls samples as well.
// reset (rst, synchronous) clears the sum, the sample count and the output
// valid, and sets window_length to 500.
module windowed_rms_level_meter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [wrms_pkg::IN_W-1:0]    sample,
  input  logic                         window_length_we,
  input  logic [wrms_pkg::WIN_W-1:0]   window_length,
  output logic                         rms_valid,
  input  logic                         rms_stall,
  output logic [wrms_pkg::ROOT_W-1:0]  rms_level
);

  wrms_pkg::cmd_t    cmd;
  wrms_pkg::status_t status;

  wrms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  wrms_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .sample           (sample),
    .window_length_we (window_length_we),
    .window_length    (window_length),
    .cmd              (cmd),
    .status           (status),
    .rms_valid        (rms_valid),
    .rms_stall        (rms_stall),
    .rms_level        (rms_level)
  );

endmodule
